>>> sv/kepler_newton_solver_defines.svh
// Assertion macros used by the checker file.
`ifndef KEPLER_NEWTON_SOLVER_DEFINES_SVH
`define KEPLER_NEWTON_SOLVER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KNS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kepler_newton_solver: assertion failed");

// Next-cycle implication, checked outside reset.
`define KNS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kepler_newton_solver: assertion failed");

`endif

>>> sv/kns_pkg.sv
package kns_pkg;

  // Q30 constants used by range reduction, CORDIC and the derivative.
  localparam logic signed [63:0] Q30_ONE      = 64'sd1073741824;
  localparam logic signed [63:0] Q30_PI       = 64'sd3373259426;
  localparam logic signed [63:0] Q30_TWO_PI   = 64'sd6746518852;
  localparam logic signed [63:0] Q30_HALF_PI  = 64'sd1686629713;
  localparam logic signed [63:0] Q30_CORDIC_K = 64'sd652032874;

  // Step magnitude cap, widths of the divider operands and range-reduction parameters.
  localparam int STEP_CAP_BIT = 33;
  localparam int Q_W  = STEP_CAP_BIT + 1;
  localparam int N_W  = 48;
  localparam int D_W  = 33;
  localparam int MOD_STEPS = 17;
  localparam int MOD_BASE  = 15;

  // Register indexes on the configuration port.
  localparam logic REG_TOLERANCE = 1'b0;
  localparam logic REG_ITER_LIMIT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic prep;
    logic mod_step;
    logic fold;
    logic cordic_step;
    logic mul;
    logic resid;
    logic div_step;
    logic update;
  } kns_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv;
  } kns_status_t;

  // Arctangent of 2^-i in Q30, rounded to nearest.
  function automatic logic signed [63:0] atan_q30(input int unsigned i);
    logic signed [63:0] v;
    v = 64'sd0;
    case (i)
      0: v = 64'sd843314857;
      1: v = 64'sd497837829;
      2: v = 64'sd263043837;
      3: v = 64'sd133525159;
      4: v = 64'sd67021687;
      5: v = 64'sd33543516;
      6: v = 64'sd16775851;
      7: v = 64'sd8388437;
      8: v = 64'sd4194283;
      9: v = 64'sd2097149;
      10: v = 64'sd1048576;
      default: begin
        if (i <= 30) v = 64'sd1 <<< (30 - i);
      end
    endcase
    return v;
  endfunction

endpackage

>>> sv/kns_ctrl.sv
module kns_ctrl import kns_pkg::*; #(
  parameter int CORDIC_STEPS = 30,
  parameter int DIV_STEPS = 76,
  parameter int CNT_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [7:0]       iter_limit,
  input  kns_status_t      status,
  output kns_cmd_t         cmd,
  output logic [CNT_W-1:0] cnt,
  output logic             busy,
  output logic             out_valid
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_PREP   = 10'b0000000010,
    S_MOD    = 10'b0000000100,
    S_FOLD   = 10'b0000001000,
    S_CORDIC = 10'b0000010000,
    S_MUL    = 10'b0000100000,
    S_RESID  = 10'b0001000000,
    S_DIV    = 10'b0010000000,
    S_UPDATE = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  localparam logic [CNT_W-1:0] MOD_LAST    = CNT_W'(MOD_STEPS - 1);
  localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(DIV_STEPS - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       iter_r, iter_nxt;

  // Next-state logic and step counters.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    iter_nxt = iter_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          iter_nxt = '0;
          state_nxt = (iter_limit == 8'd0) ? S_DONE : S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        cnt_nxt = '0;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MOD_LAST) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        cnt_nxt = '0;
        state_nxt = S_CORDIC;
      end
      S_CORDIC: begin
        cmd.cordic_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CORDIC_LAST) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = S_RESID;
      end
      S_RESID: begin
        cmd.resid = 1'b1;
        cnt_nxt = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        if (status.conv || ({1'b0, iter_r} + 9'd1 == {1'b0, iter_limit})) begin
          state_nxt = S_DONE;
        end else begin
          iter_nxt = iter_r + 8'd1;
          state_nxt = S_PREP;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      iter_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      iter_r <= iter_nxt;
    end
  end

  assign cnt = cnt_r;
  assign busy = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

>>> sv/kns_datapath.sv
module kns_datapath import kns_pkg::*; #(
  parameter int FRAC_BITS = 28,
  parameter int CNT_W = 7
) (
  input  logic               clk,
  input  kns_cmd_t           cmd,
  input  logic [CNT_W-1:0]   cnt,
  input  logic [28:0]        tolerance,
  input  logic signed [31:0] mean_anomaly,
  input  logic [15:0]        eccentricity,
  input  logic signed [31:0] start_guess,
  output kns_status_t        status,
  output logic signed [31:0] eccentric_anomaly,
  output logic               converged
);

  localparam int SH_L = (FRAC_BITS < 30) ? 30 - FRAC_BITS : 0;
  localparam int SH_R = (FRAC_BITS >= 30) ? FRAC_BITS - 30 : 0;
  localparam logic signed [31:0] NEG_ONE = (FRAC_BITS >= 31) ? 32'sh80000000 :
                                           32'(-(64'sd1 <<< FRAC_BITS));
  localparam logic [Q_W-1:0] STEP_CAP = Q_W'(1) << STEP_CAP_BIT;
  localparam logic [CNT_W-1:0] MOD_TOP = CNT_W'(MOD_STEPS - 1);

  function automatic logic signed [63:0] to_q30(input logic signed [63:0] v);
    return (v <<< SH_L) >>> SH_R;
  endfunction

  function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > 64'sd2147483647) r = 64'sd2147483647;
    else if (v < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  logic signed [63:0] m30_r, a30_r, v_r, x_r, y_r, z_r;
  logic signed [31:0] e_r, res_r;
  logic [15:0]        ecc_r;
  logic               neg_r, fneg_r, ovf_r, conv_r;
  logic signed [49:0] es_r, ec_r;
  logic [N_W-1:0]     n_r;
  logic [D_W-1:0]     d_r, rem_r;
  logic [Q_W-1:0]     q_r;

  logic signed [63:0] a30, v0, sub, z0, xs, ys, atan_v, s_v, c_v, f_v, fp_v;
  logic signed [63:0] ev, nx, diff;
  logic signed [32:0] s33, c33;
  logic signed [16:0] ecc_s;
  logic [D_W:0]       trial;
  logic [Q_W-1:0]     qv;
  logic               conv;

  // Combinational step logic for each phase.
  always_comb begin
    a30 = to_q30(64'(e_r));
    v0 = a30 + Q30_PI;
    if (v0 < 0) v0 = v0 + (Q30_TWO_PI <<< MOD_BASE);
    sub = Q30_TWO_PI <<< (MOD_TOP - cnt);
    z0 = v_r - Q30_PI;
    xs = x_r >>> cnt;
    ys = y_r >>> cnt;
    atan_v = atan_q30(32'(cnt));
    s_v = neg_r ? -y_r : y_r;
    c_v = neg_r ? -x_r : x_r;
    s33 = s_v[32:0];
    c33 = c_v[32:0];
    ecc_s = {1'b0, ecc_r};
    f_v = a30_r - 64'(es_r >>> 16) - m30_r;
    fp_v = Q30_ONE - 64'(ec_r >>> 16);
    if (fp_v < 64'sd1) fp_v = 64'sd1;
    trial = {rem_r, n_r[N_W-1]};
    qv = (ovf_r || (q_r > STEP_CAP)) ? STEP_CAP : q_r;
    ev = 64'(e_r);
    nx = fneg_r ? sat32(ev + $signed(64'(qv))) : sat32(ev - $signed(64'(qv)));
    diff = nx - ev;
    if (diff < 0) diff = -diff;
    conv = (diff < $signed(64'(tolerance)));
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m30_r <= to_q30(64'(mean_anomaly));
      e_r <= start_guess;
      ecc_r <= eccentricity;
      res_r <= NEG_ONE;
      conv_r <= 1'b0;
    end
    if (cmd.prep) begin
      a30_r <= a30;
      v_r <= v0;
    end
    // Range reduction by conditional subtraction of scaled 2*pi.
    if (cmd.mod_step && (v_r >= sub)) v_r <= v_r - sub;
    // Fold into [-pi/2, pi/2] and seed the rotation.
    if (cmd.fold) begin
      x_r <= Q30_CORDIC_K;
      y_r <= 64'sd0;
      if (z0 > Q30_HALF_PI) begin
        z_r <= z0 - Q30_PI;
        neg_r <= 1'b1;
      end else if (z0 < -Q30_HALF_PI) begin
        z_r <= z0 + Q30_PI;
        neg_r <= 1'b1;
      end else begin
        z_r <= z0;
        neg_r <= 1'b0;
      end
    end
    // One CORDIC rotation per cycle.
    if (cmd.cordic_step) begin
      if (z_r >= 0) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_v;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_v;
      end
    end
    if (cmd.mul) begin
      es_r <= ecc_s * s33;
      ec_r <= ecc_s * c33;
    end
    // Residual and derivative; set up the divider.
    if (cmd.resid) begin
      fneg_r <= f_v[63];
      n_r <= f_v[63] ? N_W'(-f_v) : N_W'(f_v);
      d_r <= fp_v[D_W-1:0];
      rem_r <= '0;
      q_r <= '0;
      ovf_r <= 1'b0;
    end
    // One quotient bit per cycle, restoring.
    if (cmd.div_step) begin
      n_r <= {n_r[N_W-2:0], 1'b0};
      ovf_r <= ovf_r | q_r[Q_W-1];
      if (trial >= {1'b0, d_r}) begin
        rem_r <= D_W'(trial - {1'b0, d_r});
        q_r <= {q_r[Q_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[D_W-1:0];
        q_r <= {q_r[Q_W-2:0], 1'b0};
      end
    end
    if (cmd.update) begin
      e_r <= nx[31:0];
      if (conv) begin
        res_r <= nx[31:0];
        conv_r <= 1'b1;
      end
    end
  end

  assign status.conv = conv;
  assign eccentric_anomaly = res_r;
  assign converged = conv_r;

endmodule

>>> sv/kepler_newton_solver.sv
// Kepler equation solver: one transaction on start (while busy is low) gives exactly one
// result, shown for a single cycle with out_valid; the receiver cannot stall, so the
// result must be taken in that cycle. Each Newton step runs through the range reduction,
// the one-rotation-per-cycle CORDIC and the bit-serial divider, and an item tries up to
// iteration_limit steps. busy stays high until the result has been shown.
module kepler_newton_solver import kns_pkg::*; #(
  parameter int FRAC_BITS = 28,
  parameter int CORDIC_STEPS = 30
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_mean_anomaly,
  input  logic [15:0]        in_eccentricity,
  input  logic signed [31:0] in_start_guess,
  output logic               out_valid,
  output logic signed [31:0] out_eccentric_anomaly,
  output logic               out_converged,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int DIV_STEPS = N_W + FRAC_BITS;
  localparam int MAX_STEPS = (DIV_STEPS > CORDIC_STEPS) ? DIV_STEPS : CORDIC_STEPS;
  localparam int CNT_W = $clog2(MAX_STEPS + 1);

  logic [28:0] tol_r;
  logic [7:0]  lim_r;
  kns_cmd_t    cmd;
  kns_status_t status;
  logic [CNT_W-1:0] cnt;

  // Configuration registers on the APB port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= 29'd268;
      lim_r <= 8'd100;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_TOLERANCE:  tol_r <= pwdata[28:0];
        REG_ITER_LIMIT: lim_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ITER_LIMIT) ? {24'd0, lim_r} : {3'd0, tol_r};

  kns_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .DIV_STEPS(DIV_STEPS),
    .CNT_W(CNT_W)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .iter_limit(lim_r),
    .status(status),
    .cmd(cmd),
    .cnt(cnt),
    .busy(busy),
    .out_valid(out_valid)
  );

  kns_datapath #(
    .FRAC_BITS(FRAC_BITS),
    .CNT_W(CNT_W)
  ) u_datapath (
    .clk(clk),
    .cmd(cmd),
    .cnt(cnt),
    .tolerance(tol_r),
    .mean_anomaly(in_mean_anomaly),
    .eccentricity(in_eccentricity),
    .start_guess(in_start_guess),
    .status(status),
    .eccentric_anomaly(out_eccentric_anomaly),
    .converged(out_converged)
  );

endmodule

>>> sv/kns_checker.sv
`include "kepler_newton_solver_defines.svh"

module kns_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // An accepted transaction makes the block busy.
  `KNS_ASSERT_NXT(a_busy_after_accept, start && !busy, busy)
  // A result only appears while a transaction is in flight.
  `KNS_ASSERT_IMP(a_valid_while_busy, out_valid, busy)
  // After its result the block is free again, and the strobe lasts one cycle.
  `KNS_ASSERT_NXT(a_idle_after_result, out_valid, !busy && !out_valid)

endmodule

bind kepler_newton_solver kns_checker u_kns_checker (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .out_valid(out_valid)
);

>>> test/tb_kepler_newton_solver.sv
module tb_kepler_newton_solver;
  timeunit 1ns;
  timeprecision 1ps;

  // Fixed-point constants of the solver, Q30 unless noted.
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint TWO_PI_Q30  = 64'sd6746518852;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam longint GAIN_Q30    = 64'sd652032874;
  localparam longint unsigned MAX_STEP = 64'd1 << 33;
  localparam logic signed [31:0] NO_SOLUTION = 32'shF000_0000;
  localparam logic signed [31:0] PI_Q28 = 32'sd843314857;

  // Byte addresses of the configuration registers.
  localparam logic [2:0] ADDR_TOLERANCE  = 3'd0;
  localparam logic [2:0] ADDR_ITER_LIMIT = 3'd4;

  localparam longint ARCTAN_HEAD [11] = '{843314857, 497837829, 263043837, 133525159,
    67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576};

  typedef struct {
    logic signed [31:0] mean_anomaly;
    logic [15:0]        eccentricity;
    logic signed [31:0] start_guess;
  } orbit_t;

  typedef struct {
    logic signed [31:0] eccentric_anomaly;
    logic               converged;
  } solution_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] in_mean_anomaly = '0;
  logic [15:0]        in_eccentricity = '0;
  logic signed [31:0] in_start_guess = '0;
  logic               out_valid;
  logic signed [31:0] out_eccentric_anomaly;
  logic               out_converged;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  orbit_t    orbit_queue[$];
  solution_t solution_queue[$];
  logic [28:0] tol_setting = 29'd268;
  logic [7:0]  limit_setting = 8'd100;
  int          errors = 0;
  logic        took = 1'b0;
  int          burst_left = 1;
  int          gap_left = 0;

  kepler_newton_solver u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mean_anomaly(in_mean_anomaly), .in_eccentricity(in_eccentricity),
    .in_start_guess(in_start_guess), .out_valid(out_valid),
    .out_eccentric_anomaly(out_eccentric_anomaly), .out_converged(out_converged),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Saturate to the signed 32-bit range.
  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint arctan_q30(input int i);
    if (i < 11) return ARCTAN_HEAD[i];
    if (i <= 30) return 64'sd1 <<< (30 - i);
    return 0;
  endfunction

  // Newton iteration on Kepler's equation with CORDIC sine and cosine.
  function automatic solution_t solve_kepler(input orbit_t o, input logic [28:0] tol,
                                             input logic [7:0] lim);
    solution_t res;
    longint m30, ecc, e, s, c, f, fp, nxt, diff, r, x, y, z, xs, ys;
    longint unsigned q, n, rem;
    bit neg;
    m30 = longint'(o.mean_anomaly) * 4;
    ecc = longint'(o.eccentricity);
    e = longint'(o.start_guess);
    res.eccentric_anomaly = NO_SOLUTION;
    res.converged = 1'b0;
    for (int it = 0; it < lim; it++) begin
      // Reduce to [-pi, pi), then fold into [-pi/2, pi/2].
      r = (e * 4 + PI_Q30) % TWO_PI_Q30;
      if (r < 0) r += TWO_PI_Q30;
      z = r - PI_Q30;
      neg = 1'b0;
      if (z > HALF_PI_Q30) begin
        z -= PI_Q30;
        neg = 1'b1;
      end else if (z < -HALF_PI_Q30) begin
        z += PI_Q30;
        neg = 1'b1;
      end
      x = GAIN_Q30;
      y = 0;
      for (int i = 0; i < 30; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys;
          y += xs;
          z -= arctan_q30(i);
        end else begin
          x += ys;
          y -= xs;
          z += arctan_q30(i);
        end
      end
      s = neg ? -y : y;
      c = neg ? -x : x;
      f = e * 4 - ((ecc * s) >>> 16) - m30;
      fp = ONE_Q30 - ((ecc * c) >>> 16);
      if (fp < 1) fp = 1;
      // Long division of |f| * 2^28 by fp, capped in magnitude.
      n = (f < 0) ? longint'(-f) : longint'(f);
      q = n / longint'(fp);
      rem = n % longint'(fp);
      if (q > MAX_STEP) q = MAX_STEP;
      for (int k = 0; k < 28; k++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= longint'(fp)) begin
          rem -= longint'(fp);
          q |= 1;
        end
        if (q > MAX_STEP) q = MAX_STEP;
      end
      nxt = (f < 0) ? clip32(e + longint'(q)) : clip32(e - longint'(q));
      diff = nxt - e;
      if (diff < 0) diff = -diff;
      if (diff < longint'(tol)) begin
        res.eccentric_anomaly = nxt[31:0];
        res.converged = 1'b1;
        break;
      end
      e = nxt;
    end
    return res;
  endfunction

  // Observe accepted transactions and results at the rising edge.
  always @(posedge clk) begin
    orbit_t o;
    solution_t want;
    took <= rst_n && start && !busy;
    if (rst_n && start && !busy) begin
      o.mean_anomaly = in_mean_anomaly;
      o.eccentricity = in_eccentricity;
      o.start_guess = in_start_guess;
      solution_queue.push_back(solve_kepler(o, tol_setting, limit_setting));
    end
    if (rst_n && out_valid) begin
      if (solution_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual E=%0d conv=%0b",
                 $realtime, out_eccentric_anomaly, out_converged);
        errors++;
      end else begin
        want = solution_queue.pop_front();
        if (out_eccentric_anomaly !== want.eccentric_anomaly) begin
          $display("%0t: eccentric_anomaly mismatch, expected %0d, actual %0d",
                   $realtime, want.eccentric_anomaly, out_eccentric_anomaly);
          errors++;
        end
        if (out_converged !== want.converged) begin
          $display("%0t: converged mismatch, expected %0b, actual %0b",
                   $realtime, want.converged, out_converged);
          errors++;
        end
      end
    end
  end

  // Feed pending transactions in bursts, changing inputs at the falling edge.
  always @(negedge clk) begin
    bit go;
    if (rst_n) begin
      if (took) void'(orbit_queue.pop_front());
      go = start && !took;
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (orbit_queue.size() > 0) begin
          go = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
          end
        end
      end
      start <= go;
      if (go) begin
        in_mean_anomaly <= orbit_queue[0].mean_anomaly;
        in_eccentricity <= orbit_queue[0].eccentricity;
        in_start_guess <= orbit_queue[0].start_guess;
      end
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_TOLERANCE) tol_setting = data[28:0];
    else if (addr == ADDR_ITER_LIMIT) limit_setting = data[7:0];
  endtask

  task automatic wait_idle();
    while (orbit_queue.size() != 0 || solution_queue.size() != 0 || start)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic add_orbit(input logic [31:0] m, input logic [15:0] ecc,
                           input logic [31:0] g);
    orbit_t o;
    o.mean_anomaly = m;
    o.eccentricity = ecc;
    o.start_guess = g;
    orbit_queue.push_back(o);
  endtask

  // Mostly physical orbits near the principal range, some raw noise.
  task automatic add_random(input int count);
    logic signed [31:0] m;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        add_orbit($urandom, $urandom, $urandom);
      end else begin
        m = $signed($urandom_range(0, 2 * PI_Q28)) - PI_Q28;
        add_orbit(m, $urandom, ($urandom_range(0, 1) == 0) ? m :
                  m + $signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed cases at the reset settings.
    add_orbit(32'd0, 16'd0, 32'd0);
    add_orbit(32'h7FFF_FFFF, 16'hFFFF, 32'h8000_0000);
    add_orbit(32'h8000_0000, 16'hFFFF, 32'h7FFF_FFFF);
    add_orbit(32'h7FFF_FFFF, 16'd0, 32'h7FFF_FFFF);
    add_orbit(32'h8000_0000, 16'd0, 32'h8000_0000);
    add_orbit(PI_Q28, 16'hFFFF, 32'd0);
    add_orbit(-PI_Q28, 16'hFFFF, PI_Q28);
    add_orbit(32'h1000_0000, 16'h8000, 32'h1000_0000);
    add_orbit(32'hF000_0000, 16'hFFFF, 32'hF000_0000);
    add_orbit(32'h0000_0001, 16'hFFFF, 32'h0000_0000);
    add_orbit(32'h5555_5555, 16'hAAAA, 32'hAAAA_AAAA);
    add_orbit(32'hAAAA_AAAA, 16'h5555, 32'h5555_5555);
    wait_idle();

    // Tightest tolerance with the largest step budget.
    reg_write(ADDR_TOLERANCE, 32'd1);
    reg_write(ADDR_ITER_LIMIT, 32'd255);
    add_orbit(32'h0800_0000, 16'h4000, 32'h0800_0000);
    add_orbit(32'h7FFF_FFFF, 16'hFFFF, 32'h8000_0000);
    add_random(4);
    wait_idle();

    // A loose tolerance with a single step.
    reg_write(ADDR_TOLERANCE, 32'h1000_0000);
    reg_write(ADDR_ITER_LIMIT, 32'd1);
    add_orbit(32'h8000_0000, 16'hFFFF, 32'h7FFF_FFFF);
    add_random(100);
    wait_idle();

    // Random tolerance and a moderate step budget.
    reg_write(ADDR_TOLERANCE, $urandom_range(100, 100000));
    reg_write(ADDR_ITER_LIMIT, 32'd30);
    add_random(150);
    wait_idle();

    // Reset-like tolerance with a short budget.
    reg_write(ADDR_TOLERANCE, 32'd268);
    reg_write(ADDR_ITER_LIMIT, $urandom_range(8, 16));
    add_random(130);
    wait_idle();

    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #60ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> kepler_newton_solver.f
+incdir+sv
sv/kns_pkg.sv
sv/kns_ctrl.sv
sv/kns_datapath.sv
sv/kepler_newton_solver.sv
sv/kns_checker.sv
test/tb_kepler_newton_solver.sv
